[sv/ffba_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the first-fit allocator.
// No dependencies; used by the cell, the sequencer and the top level.
package ffba_pkg;

    localparam int FUNC_W = 1;
    localparam int REQ_W  = 21;
    localparam int OFF_W  = 20;
    localparam int STAT_W = 2;

    localparam int DEF_ARENA_BYTES  = 1048576;
    localparam int DEF_HEADER_BYTES = 24;
    localparam int DEF_MAX_BLOCKS   = 64;

    localparam int ALIGN_LOW      = 7;
    localparam int MIN_SPLIT_REST = 8;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 1'b0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADREL = 2'd2;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_START,
        CMD_SCAN,
        CMD_TAKE,
        CMD_SPLIT,
        CMD_FREE,
        CMD_MRG_R,
        CMD_MRG_L
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic is_rel;
    } t_ctl;

    typedef struct packed {
        logic hit;
        logic miss;
        logic split;
        logic mrg_r;
        logic mrg_l;
    } t_cell_stat;

endpackage

[sv/ffba_cell.sv]
`timescale 1ns / 1ps
// One table entry of the allocator chain: start, size, free mark, scan token.
// Depends on ffba_pkg; talks only to its two neighbors and the broadcast control.
module ffba_cell #(
    parameter int ARENA_BYTES  = ffba_pkg::DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
    parameter int SW           = 21,
    parameter int NW           = 22,
    parameter bit IS_FIRST     = 1'b0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ffba_pkg::t_ctl            i_ctl,
    input  logic [NW-1:0]             i_need,
    input  logic [ffba_pkg::OFF_W-1:0] i_rel,
    input  logic                      i_room,
    input  logic [SW-1:0]             i_l_start,
    input  logic [SW-1:0]             i_l_size,
    input  logic                      i_l_free,
    input  logic                      i_l_valid,
    input  logic                      i_l_tok,
    input  logic                      i_l_pass,
    input  logic [SW-1:0]             i_rem_start,
    input  logic [SW-1:0]             i_rem_size,
    input  logic [SW-1:0]             i_r_start,
    input  logic [SW-1:0]             i_r_size,
    input  logic                      i_r_free,
    input  logic                      i_r_valid,
    input  logic                      i_r_tok,
    output logic [SW-1:0]             o_start,
    output logic [SW-1:0]             o_size,
    output logic                      o_free,
    output logic                      o_valid,
    output logic                      o_tok,
    output logic                      o_pass,
    output logic [SW-1:0]             o_rem_start,
    output logic [SW-1:0]             o_rem_size,
    output ffba_pkg::t_cell_stat      o_stat
);

    localparam int OW = ffba_pkg::OFF_W;
    localparam int CW = ((SW > NW) ? SW : NW) + 2;
    localparam int XW = ((SW > OW) ? SW : OW) + 1;
    localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);

    logic [SW-1:0] r_start, n_start;
    logic [SW-1:0] r_size, n_size;
    logic          r_free, n_free;
    logic          r_valid, n_valid;
    logic          r_tok, n_tok;
    logic          r_passed, n_passed;

    logic match, split_ok;

    always_comb begin
        if (i_ctl.is_rel) begin
            match = r_valid && ((XW'(r_start) + XW'(HDR)) == XW'(i_rel));
        end else begin
            match = r_valid && r_free && (CW'(r_size) >= CW'(i_need));
        end
        split_ok = (CW'(r_size) > (CW'(i_need) + CW'(HEADER_BYTES)
                   + CW'(ffba_pkg::MIN_SPLIT_REST))) && i_room;
    end

    assign o_pass      = r_tok && r_valid && !match;
    assign o_rem_start = r_start + HDR + SW'(i_need);
    assign o_rem_size  = r_size - SW'(i_need) - HDR;

    always_comb begin
        o_stat.hit   = r_tok && match;
        o_stat.miss  = r_tok && !r_valid;
        o_stat.split = r_tok && match && split_ok;
        o_stat.mrg_r = r_tok && match && i_r_valid && i_r_free;
        o_stat.mrg_l = r_tok && match && i_l_free;
    end

    always_comb begin
        n_start  = r_start;
        n_size   = r_size;
        n_free   = r_free;
        n_valid  = r_valid;
        n_tok    = r_tok;
        n_passed = r_passed;
        case (i_ctl.cmd)
            ffba_pkg::CMD_START: begin
                n_tok    = IS_FIRST;
                n_passed = 1'b0;
            end
            ffba_pkg::CMD_SCAN: begin
                if (o_pass) begin
                    n_tok    = 1'b0;
                    n_passed = 1'b1;
                end
                if (i_l_pass) begin
                    n_tok = 1'b1;
                end
            end
            ffba_pkg::CMD_TAKE: begin
                if (r_tok) begin
                    n_free = 1'b0;
                end
            end
            ffba_pkg::CMD_SPLIT: begin
                if (r_tok) begin
                    n_size = SW'(i_need);
                    n_free = 1'b0;
                end else if (i_l_tok) begin
                    n_start = i_rem_start;
                    n_size  = i_rem_size;
                    n_free  = 1'b1;
                    n_valid = 1'b1;
                end else if (!r_passed) begin
                    n_start = i_l_start;
                    n_size  = i_l_size;
                    n_free  = i_l_free;
                    n_valid = i_l_valid;
                end
            end
            ffba_pkg::CMD_FREE: begin
                if (r_tok) begin
                    n_free = 1'b1;
                end
            end
            ffba_pkg::CMD_MRG_R: begin
                if (r_tok) begin
                    n_size = r_size + HDR + i_r_size;
                end else if (!r_passed) begin
                    n_start = i_r_start;
                    n_size  = i_r_size;
                    n_free  = i_r_free;
                    n_valid = i_r_valid;
                end
            end
            ffba_pkg::CMD_MRG_L: begin
                // left neighbor of the released block absorbs it
                if (i_r_tok) begin
                    n_size = r_size + HDR + i_r_size;
                end else if (r_tok || !r_passed) begin
                    n_start = i_r_start;
                    n_size  = i_r_size;
                    n_free  = i_r_free;
                    n_valid = i_r_valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_size   <= IS_FIRST ? SW'(ARENA_BYTES - HEADER_BYTES) : '0;
            r_free   <= IS_FIRST;
            r_valid  <= IS_FIRST;
            r_tok    <= 1'b0;
            r_passed <= 1'b0;
        end else begin
            r_start  <= n_start;
            r_size   <= n_size;
            r_free   <= n_free;
            r_valid  <= n_valid;
            r_tok    <= n_tok;
            r_passed <= n_passed;
        end
    end

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_free  = r_free;
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

[sv/ffba_seq.sv]
`timescale 1ns / 1ps
// Request sequencer: takes a word, steers the cell chain, holds the result word.
// Depends on ffba_pkg.
module ffba_seq #(
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
    parameter int SW           = 21,
    parameter int NW           = 22
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ffba_pkg::FUNC_W-1:0] i_func,
    input  logic [ffba_pkg::REQ_W-1:0]  i_request_size,
    input  logic [ffba_pkg::OFF_W-1:0]  i_release_offset,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ffba_pkg::STAT_W-1:0] o_status,
    output logic [ffba_pkg::OFF_W-1:0]  o_payload_offset,
    input  ffba_pkg::t_cell_stat        i_stat,
    input  logic [SW-1:0]               i_sel_start,
    output ffba_pkg::t_ctl              o_ctl,
    output logic [NW-1:0]               o_need,
    output logic [ffba_pkg::OFF_W-1:0]  o_rel
);

    localparam int OW = ffba_pkg::OFF_W;
    localparam int PW = ((SW > OW) ? SW : OW) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_APPLY = 6'b000100,
        S_MRGR  = 6'b001000,
        S_MRGL  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_rel, n_is_rel;
    logic [NW-1:0] r_need, n_need;
    logic [OW-1:0] r_rel, n_rel;
    logic   r_split, n_split;
    logic   r_mr, n_mr;
    logic   r_ml, n_ml;
    logic [ffba_pkg::STAT_W-1:0] r_res_st, n_res_st;
    logic [OW-1:0] r_res_off, n_res_off;
    logic   r_ovalid, n_ovalid;
    logic [ffba_pkg::STAT_W-1:0] r_ost, n_ost;
    logic [OW-1:0] r_ooff, n_ooff;
    logic   accept;
    logic [PW-1:0] pay_sum;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign pay_sum = PW'(i_sel_start) + PW'(HEADER_BYTES);

    always_comb begin
        n_state   = r_state;
        n_is_rel  = r_is_rel;
        n_need    = r_need;
        n_rel     = r_rel;
        n_split   = r_split;
        n_mr      = r_mr;
        n_ml      = r_ml;
        n_res_st  = r_res_st;
        n_res_off = r_res_off;
        n_ovalid  = r_ovalid && i_stall;
        n_ost     = r_ost;
        n_ooff    = r_ooff;
        o_ctl.cmd    = ffba_pkg::CMD_IDLE;
        o_ctl.is_rel = r_is_rel;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_is_rel  = (i_func == ffba_pkg::FN_RELEASE);
                    n_need    = (NW'(i_request_size) + NW'(ffba_pkg::ALIGN_LOW))
                                & ~NW'(ffba_pkg::ALIGN_LOW);
                    n_rel     = i_release_offset;
                    n_res_st  = ffba_pkg::ST_OK;
                    n_res_off = '0;
                    if (i_func == ffba_pkg::FN_ALLOC && i_request_size == '0) begin
                        n_res_st = ffba_pkg::ST_NOFIT;
                        n_state  = S_EMIT;
                    end else if (i_func == ffba_pkg::FN_RELEASE && i_release_offset == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        o_ctl.cmd = ffba_pkg::CMD_START;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_ctl.cmd = ffba_pkg::CMD_SCAN;
                if (i_stat.hit) begin
                    n_split = i_stat.split;
                    n_mr    = i_stat.mrg_r;
                    n_ml    = i_stat.mrg_l;
                    n_state = S_APPLY;
                end else if (i_stat.miss) begin
                    n_res_st = r_is_rel ? ffba_pkg::ST_BADREL : ffba_pkg::ST_NOFIT;
                    n_state  = S_EMIT;
                end
            end
            S_APPLY: begin
                if (r_is_rel) begin
                    o_ctl.cmd = ffba_pkg::CMD_FREE;
                    if (r_mr) begin
                        n_state = S_MRGR;
                    end else if (r_ml) begin
                        n_state = S_MRGL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    o_ctl.cmd = r_split ? ffba_pkg::CMD_SPLIT : ffba_pkg::CMD_TAKE;
                    n_res_off = pay_sum[OW-1:0];
                    n_state   = S_EMIT;
                end
            end
            S_MRGR: begin
                o_ctl.cmd = ffba_pkg::CMD_MRG_R;
                n_state   = r_ml ? S_MRGL : S_EMIT;
            end
            S_MRGL: begin
                o_ctl.cmd = ffba_pkg::CMD_MRG_L;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_ooff   = r_res_off;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_rel  <= n_is_rel;
        r_need    <= n_need;
        r_rel     <= n_rel;
        r_split   <= n_split;
        r_mr      <= n_mr;
        r_ml      <= n_ml;
        r_res_st  <= n_res_st;
        r_res_off <= n_res_off;
        r_ost     <= n_ost;
        r_ooff    <= n_ooff;
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ost;
    assign o_payload_offset = r_ooff;
    assign o_need           = r_need;
    assign o_rel            = r_rel;

endmodule

[sv/first_fit_block_allocator_unit.sv]
`timescale 1ns / 1ps
// First-fit block allocator top: a chain of MAX_BLOCKS entry cells plus a sequencer.
// A zero-size allocate or null release skips the scan; otherwise the scan token
// walks one cell per cycle to the hit, then the entry is taken, split or freed and merged.
// One word in flight at a time.
// Reset (synchronous, active low) leaves one free block of arena minus one header.
// Depends on ffba_pkg, ffba_cell, ffba_seq.
module first_fit_block_allocator_unit #(
    parameter int ARENA_BYTES  = ffba_pkg::DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
    parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ffba_pkg::FUNC_W-1:0] i_func,
    input  logic [ffba_pkg::REQ_W-1:0]  i_request_size,
    input  logic [ffba_pkg::OFF_W-1:0]  i_release_offset,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ffba_pkg::STAT_W-1:0] o_status,
    output logic [ffba_pkg::OFF_W-1:0]  o_payload_offset
);

    localparam int SW = $clog2(ARENA_BYTES + 1);
    localparam int NW = ffba_pkg::REQ_W + 1;
    localparam int M  = MAX_BLOCKS;

    ffba_pkg::t_ctl       w_ctl;
    logic [NW-1:0]        w_need;
    logic [ffba_pkg::OFF_W-1:0] w_rel;
    logic                 w_room;

    logic [SW-1:0] w_start [M];
    logic [SW-1:0] w_size  [M];
    logic [SW-1:0] w_rem_start [M];
    logic [SW-1:0] w_rem_size  [M];
    logic [M-1:0]  w_free, w_valid, w_tok, w_pass;
    ffba_pkg::t_cell_stat w_cstat [M];
    ffba_pkg::t_cell_stat w_stat;
    logic [SW-1:0] w_sel_start;

    assign w_room = !w_valid[M-1];

    for (genvar j = 0; j < M; j++) begin : g_cell
        logic [SW-1:0] l_start, l_size, l_rem_start, l_rem_size, r_start, r_size;
        logic          l_free, l_valid, l_tok, l_pass, r_free, r_valid, r_tok;
        if (j == 0) begin : g_lend
            assign l_start = '0;
            assign l_size = '0;
            assign l_rem_start = '0;
            assign l_rem_size = '0;
            assign l_free = 1'b0;
            assign l_valid = 1'b0;
            assign l_tok = 1'b0;
            assign l_pass = 1'b0;
        end else begin : g_lmid
            assign l_start = w_start[j-1];
            assign l_size = w_size[j-1];
            assign l_rem_start = w_rem_start[j-1];
            assign l_rem_size = w_rem_size[j-1];
            assign l_free = w_free[j-1];
            assign l_valid = w_valid[j-1];
            assign l_tok = w_tok[j-1];
            assign l_pass = w_pass[j-1];
        end
        if (j == M - 1) begin : g_rend
            assign r_start = '0;
            assign r_size = '0;
            assign r_free = 1'b0;
            assign r_valid = 1'b0;
            assign r_tok = 1'b0;
        end else begin : g_rmid
            assign r_start = w_start[j+1];
            assign r_size = w_size[j+1];
            assign r_free = w_free[j+1];
            assign r_valid = w_valid[j+1];
            assign r_tok = w_tok[j+1];
        end
        ffba_cell #(
            .ARENA_BYTES (ARENA_BYTES),
            .HEADER_BYTES(HEADER_BYTES),
            .SW          (SW),
            .NW          (NW),
            .IS_FIRST    (j == 0)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_need      (w_need),
            .i_rel       (w_rel),
            .i_room      (w_room),
            .i_l_start   (l_start),
            .i_l_size    (l_size),
            .i_l_free    (l_free),
            .i_l_valid   (l_valid),
            .i_l_tok     (l_tok),
            .i_l_pass    (l_pass),
            .i_rem_start (l_rem_start),
            .i_rem_size  (l_rem_size),
            .i_r_start   (r_start),
            .i_r_size    (r_size),
            .i_r_free    (r_free),
            .i_r_valid   (r_valid),
            .i_r_tok     (r_tok),
            .o_start     (w_start[j]),
            .o_size      (w_size[j]),
            .o_free      (w_free[j]),
            .o_valid     (w_valid[j]),
            .o_tok       (w_tok[j]),
            .o_pass      (w_pass[j]),
            .o_rem_start (w_rem_start[j]),
            .o_rem_size  (w_rem_size[j]),
            .o_stat      (w_cstat[j])
        );
    end

    // token is one-hot, so an OR over the cells picks the marked entry
    always_comb begin
        w_stat      = '0;
        w_sel_start = '0;
        for (int j = 0; j < M; j++) begin
            w_stat      = w_stat | w_cstat[j];
            w_sel_start = w_sel_start | (w_tok[j] ? w_start[j] : '0);
        end
        // token leaving the last cell means nothing matched
        w_stat.miss = w_stat.miss | w_pass[M-1];
    end

    ffba_seq #(
        .HEADER_BYTES(HEADER_BYTES),
        .SW          (SW),
        .NW          (NW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_request_size   (i_request_size),
        .i_release_offset (i_release_offset),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset),
        .i_stat           (w_stat),
        .i_sel_start      (w_sel_start),
        .o_ctl            (w_ctl),
        .o_need           (w_need),
        .o_rel            (w_rel)
    );

`ifndef SYNTHESIS
    logic [M:0] w_valid_p1;
    assign w_valid_p1 = {1'b0, w_valid} + {{M{1'b0}}, 1'b1};

    a_tok_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok)) else $error("more than one scan token");

    a_table_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_valid_p1)) else $error("table entries not packed");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0]) else $error("first entry lost");

    a_hit_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.hit && w_stat.miss)) else $error("scan hit and miss together");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for first_fit_block_allocator_unit: a block-table predictor,
// directed and random allocate/release traffic with bursts and output stalls.
// Depends on ffba_pkg and the allocator RTL.
module tb_top;

    localparam int ARENA  = ffba_pkg::DEF_ARENA_BYTES;
    localparam int HDR    = ffba_pkg::DEF_HEADER_BYTES;
    localparam int NBLK   = ffba_pkg::DEF_MAX_BLOCKS;
    localparam int LIMIT  = 3000000;

    typedef struct packed {
        logic [ffba_pkg::STAT_W-1:0] status;
        logic [ffba_pkg::OFF_W-1:0]  offset;
    } t_alloc_res;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [ffba_pkg::FUNC_W-1:0] in_func = ffba_pkg::FN_ALLOC;
    logic [ffba_pkg::REQ_W-1:0]  in_size = '0;
    logic [ffba_pkg::OFF_W-1:0]  in_off = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ffba_pkg::STAT_W-1:0] out_status;
    logic [ffba_pkg::OFF_W-1:0]  out_offset;

    // predictor table
    int          blk_start [NBLK];
    int          blk_size  [NBLK];
    bit          blk_free  [NBLK];
    int          blk_count;

    t_alloc_res                 expected_q [$];
    logic [ffba_pkg::OFF_W-1:0] live_offs [$];
    int          n_mismatch = 0;
    int          n_results = 0;
    int          n_sent = 0;
    int          cycles = 0;
    int          hold_cycles = 0;
    bit          stall_random = 1'b1;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    first_fit_block_allocator_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_func(in_func), .i_request_size(in_size), .i_release_offset(in_off),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(out_status), .o_payload_offset(out_offset)
    );

    function automatic void table_reset();
        for (int k = 0; k < NBLK; k++) begin
            blk_start[k] = 0;
            blk_size[k]  = 0;
            blk_free[k]  = 1'b0;
        end
        blk_size[0] = ARENA - HDR;
        blk_free[0] = 1'b1;
        blk_count   = 1;
    endfunction

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_size[k]  = blk_size[k+1];
            blk_free[k]  = blk_free[k+1];
        end
        blk_count--;
        blk_start[blk_count] = 0;
        blk_size[blk_count]  = 0;
        blk_free[blk_count]  = 1'b0;
    endfunction

    function automatic t_alloc_res predict_alloc(logic [ffba_pkg::FUNC_W-1:0] fn,
                                                 logic [ffba_pkg::REQ_W-1:0] sz,
                                                 logic [ffba_pkg::OFF_W-1:0] off);
        t_alloc_res r;
        int          need;
        int          k;
        bit          hit;
        r = '{status: ffba_pkg::ST_OK, offset: '0};
        hit = 1'b0;
        if (fn == ffba_pkg::FN_ALLOC) begin
            if (sz == 0) begin
                r.status = ffba_pkg::ST_NOFIT;
            end else begin
                need = (int'(sz) + ffba_pkg::ALIGN_LOW) & ~ffba_pkg::ALIGN_LOW;
                for (int i = 0; i < blk_count && !hit; i++) begin
                    if (blk_free[i] && blk_size[i] >= need) begin
                        hit = 1'b1;
                        if (blk_size[i] > need + HDR + ffba_pkg::MIN_SPLIT_REST
                            && blk_count < NBLK) begin
                            for (k = blk_count; k > i + 1; k--) begin
                                blk_start[k] = blk_start[k-1];
                                blk_size[k]  = blk_size[k-1];
                                blk_free[k]  = blk_free[k-1];
                            end
                            blk_start[i+1] = blk_start[i] + HDR + need;
                            blk_size[i+1]  = blk_size[i] - need - HDR;
                            blk_free[i+1]  = 1'b1;
                            blk_count++;
                            blk_size[i] = need;
                        end
                        blk_free[i] = 1'b0;
                        r.offset = ffba_pkg::OFF_W'(blk_start[i] + HDR);
                    end
                end
                if (!hit) r.status = ffba_pkg::ST_NOFIT;
            end
        end else if (off != 0) begin
            for (int i = 0; i < blk_count && !hit; i++) begin
                if (blk_start[i] + HDR == int'(off)) begin
                    hit = 1'b1;
                    blk_free[i] = 1'b1;
                end
            end
            if (hit) begin
                k = 0;
                while (k + 1 < blk_count) begin
                    if (blk_free[k] && blk_free[k+1]) begin
                        blk_size[k] = blk_size[k] + HDR + blk_size[k+1];
                        drop_entry(k + 1);
                    end else begin
                        k++;
                    end
                end
            end else begin
                r.status = ffba_pkg::ST_BADREL;
            end
        end
        return r;
    endfunction

    // one word through the input handshake, prediction made at acceptance
    task automatic send_word(logic [ffba_pkg::FUNC_W-1:0] fn,
                             logic [ffba_pkg::REQ_W-1:0] sz,
                             logic [ffba_pkg::OFF_W-1:0] off);
        t_alloc_res r;
        in_valid <= 1'b1;
        in_func  <= fn;
        in_size  <= sz;
        in_off   <= off;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = predict_alloc(fn, sz, off);
        expected_q.push_back(r);
        if (fn == ffba_pkg::FN_ALLOC && r.status == ffba_pkg::ST_OK) begin
            live_offs.push_back(r.offset);
        end
        n_sent++;
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic release_any();
        int idx;
        logic [ffba_pkg::OFF_W-1:0] o;
        if (live_offs.size() == 0) begin
            send_word(ffba_pkg::FN_RELEASE, '0, '0);
        end else begin
            idx = $urandom_range(live_offs.size() - 1);
            o = live_offs[idx];
            live_offs.delete(idx);
            send_word(ffba_pkg::FN_RELEASE, ffba_pkg::REQ_W'($urandom), o);
        end
    endtask

    task automatic test_directed();
        send_word(ffba_pkg::FN_ALLOC, '0, '0);                  // zero size
        send_word(ffba_pkg::FN_ALLOC, 21'd1, 20'hFFFFF);         // rounds to 8
        send_word(ffba_pkg::FN_ALLOC, 21'd1048576, '0);          // no fit
        send_word(ffba_pkg::FN_ALLOC, 21'h1FFFFF, '0);           // all size bits high
        send_word(ffba_pkg::FN_RELEASE, '0, '0);                 // null release
        send_word(ffba_pkg::FN_RELEASE, '0, 20'hFFFFF);          // unknown offset
        send_word(ffba_pkg::FN_RELEASE, '0, 20'd23);
        send_word(ffba_pkg::FN_ALLOC, 21'd100, '0);
        send_word(ffba_pkg::FN_ALLOC, 21'd32, '0);               // near split threshold
        send_word(ffba_pkg::FN_RELEASE, '0, 20'd24);             // release first block
        send_word(ffba_pkg::FN_RELEASE, '0, 20'd24);             // double release
        send_word(ffba_pkg::FN_ALLOC, 21'd8, '0);                // reuse hole, no split
        drain();
        // fill the table so the last allocs take whole blocks
        for (int i = 0; i < NBLK + 2; i++) send_word(ffba_pkg::FN_ALLOC, 21'd16, '0);
        send_word(ffba_pkg::FN_ALLOC, 21'd1048000, '0);          // table full
        send_word(ffba_pkg::FN_ALLOC, 21'd8, '0);
        drain();
        while (live_offs.size() != 0) release_any();  // merge back to one block
        send_word(ffba_pkg::FN_ALLOC, ffba_pkg::REQ_W'(ARENA - HDR), '0); // whole arena
        release_any();
        drain();
    endtask

    task automatic test_random(int n_words);
        int burst;
        burst = 0;
        for (int i = 0; i < n_words; i++) begin
            case ($urandom_range(9))
                0:       send_word(ffba_pkg::FN_ALLOC, ffba_pkg::REQ_W'($urandom),
                                   ffba_pkg::OFF_W'($urandom));
                1:       send_word(ffba_pkg::FN_RELEASE, ffba_pkg::REQ_W'($urandom),
                                   ffba_pkg::OFF_W'($urandom));
                2, 3, 4: release_any();
                5:       send_word(ffba_pkg::FN_ALLOC,
                                   ffba_pkg::REQ_W'($urandom_range(1, 200000)),
                                   ffba_pkg::OFF_W'($urandom));
                default: send_word(ffba_pkg::FN_ALLOC,
                                   ffba_pkg::REQ_W'($urandom_range(1, 2000)),
                                   ffba_pkg::OFF_W'($urandom));
            endcase
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                repeat ($urandom_range(0, 3)) go_idle();
            end else begin
                burst--;
            end
        end
        drain();
    endtask

    // long output hold-off while the sender keeps offering words
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) begin
            send_word(ffba_pkg::FN_ALLOC, ffba_pkg::REQ_W'($urandom_range(1, 300)), '0);
        end
        drain();
        repeat (4) @(posedge clk);
    endtask

    initial begin
        table_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500);
        test_backpressure();
        test_random(500);
        repeat (NBLK + 10) @(posedge clk);
        $display("Covered %0d words, %0d results: zero size, no fit, split, full table,",
                 n_sent, n_results);
        $display("null/unknown/double release, coalescing, bursts and long output stalls.");
        if (n_mismatch == 0 && expected_q.size() == 0) begin
            $display("[first_fit_block_allocator_unit] OK");
        end else begin
            $display("[first_fit_block_allocator_unit] ERROR");
        end
        $finish;
    end

    // receiver stall pattern, with a counted long hold-off when requested
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_random) begin
            out_stall <= ($urandom_range(7) < 2) && (cycles % 512 < 384);
        end
    end

    always @(posedge clk) begin
        t_alloc_res e;
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected word: status %0d offset %0d",
                                               out_status, out_offset);
            end else begin
                e = expected_q.pop_front();
                if (e.status !== out_status || e.offset !== out_offset) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp status %0d offset %0d, got %0d %0d",
                                 e.status, e.offset, out_status, out_offset);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("[first_fit_block_allocator_unit] ERROR");
            $finish;
        end
    end
endmodule

[filelist.f]
sv/ffba_pkg.sv
sv/ffba_cell.sv
sv/ffba_seq.sv
sv/first_fit_block_allocator_unit.sv
tb/sv/tb_top.sv
